/* sv/int4_group_quant_dot_product_unit_macros.svh */
// assertion macros shared by the igqdp modules
// both expect i_clk and i_rst_n in the enclosing module
`ifndef INT4_GROUP_QUANT_DOT_PRODUCT_UNIT_MACROS_SVH
`define INT4_GROUP_QUANT_DOT_PRODUCT_UNIT_MACROS_SVH

// property checked at every clock edge outside reset
`define IGQDP_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("igqdp assertion failed");

// condition that must hold in the cycle after a trigger
`define IGQDP_ASSERT_NEXT(label, trig, cond) \
    `IGQDP_ASSERT(label, (trig) |=> (cond))

`endif

/* sv/igqdp_pkg.sv */
package igqdp_pkg;

    // default sizing
    localparam int MAX_IN_DIM_DEF = 8192;
    localparam int LANES_DEF      = 16;

    // fixed field geometry
    localparam int MAX_LANES  = 16;
    localparam int ITEM_DOT_W = 16;   // sum of 16 products in [-1016, 1024]
    localparam int ITEM_XS_W  = 12;   // sum of 16 int8 values

    // weight decode
    localparam logic [3:0]        NIB_MASK    = 4'hF;
    localparam logic signed [4:0] ZERO_OFFSET = 5'sd8;

    // reset value of the activation scale, 1.0 in Q8.24
    localparam logic [31:0] ACT_SCALE_RST = 32'h0100_0000;

    // coefficient times group term, Q.58 down to Q.24
    localparam int PROD_W    = 128;
    localparam int RND_BIT   = 33;
    localparam int TERM_LSB  = 34;
    localparam int TERM_MSB  = TERM_LSB + 63;

    localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] INT64_MIN = 64'h8000_0000_0000_0000;

    // input transaction
    typedef struct packed {
        logic [63:0]        weights_packed;
        logic [63:0]        acts_low;
        logic [63:0]        acts_high;
        logic [4:0]         valid_count;
        logic signed [31:0] weight_scale;
        logic signed [15:0] zero_minus_eight;
        logic               group_end;
        logic               row_end;
    } t_in_item;

    // output transaction
    typedef struct packed {
        logic signed [63:0] row_value;
        logic               saturated;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic lane;
        logic gacc;
        logic coef;
        logic tsub;
        logic mag;
        logic mul;
        logic round;
        logic radd;
        logic emit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic group_close;
        logic row_end;
        logic last_step;
    } t_dp_stat;

endpackage

/* sv/int4_group_quant_dot_product_unit.sv */
// W4A8 group-quantized dot product: each transaction brings up to 16 4-bit weights and
// int8 activations, accumulated per group as sum((q-8)*x) and sum(x); at a group end the
// group is scaled by weight_scale*act_scale*(dot - zero_minus_eight*xsum) into a saturating
// Q40.24 row accumulator, and a row end returns the row value and a sticky saturation flag.
// One transaction is worked at a time. A transaction that does not close a group passes
// through capture, lane reduction and group accumulate. Closing a group adds coefficient,
// group term and magnitude steps; then, NT being the number of 32-bit halves of the group
// term (2 at the default MAX_IN_DIM), the 64-bit coefficient times the group term runs as
// 2*NT partial products through one shared 32x32 multiplier, then a drain step, rounding
// and the saturating row add. A row end adds a step to load the output register, plus any
// time the previous result waits there; a new transaction is taken while a result waits.
// act_scale resets to 1.0 and may be written only while the unit is idle.
module int4_group_quant_dot_product_unit import igqdp_pkg::*; #(
    parameter int MAX_IN_DIM = MAX_IN_DIM_DEF,
    parameter int LANES      = LANES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in_item    i_in_item,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out_item   o_out_item
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencer
    igqdp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    // arithmetic and state
    igqdp_datapath #(
        .MAX_IN_DIM (MAX_IN_DIM),
        .LANES      (LANES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (i_in_item),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_out_item  (o_out_item)
    );

endmodule

/* sv/igqdp_datapath.sv */
`include "int4_group_quant_dot_product_unit_macros.svh"

module igqdp_datapath import igqdp_pkg::*; #(
    parameter int MAX_IN_DIM = MAX_IN_DIM_DEF,
    parameter int LANES      = LANES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  t_in_item    i_item,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    output t_out_item   o_out_item
);

    localparam int DOT_LIM = 1024 * MAX_IN_DIM;
    localparam int XS_LIM  = 128 * MAX_IN_DIM;
    localparam int GD_W    = $clog2(DOT_LIM + 1) + 1;
    localparam int GX_W    = $clog2(XS_LIM + 1) + 1;
    localparam int ZX_W    = 16 + GX_W;
    localparam int T_W     = ((GD_W + 10 > ZX_W) ? GD_W + 10 : ZX_W) + 1;
    localparam int NT      = (T_W + 31) / 32;
    localparam int TP_W    = NT * 32;
    localparam int STEP_W  = $clog2(2 * NT);
    localparam int SH_W    = $clog2(NT + 1);

    localparam logic signed [GD_W-1:0] DOT_HI = GD_W'(DOT_LIM);
    localparam logic signed [GD_W-1:0] DOT_LO = -DOT_HI;
    localparam logic signed [GX_W-1:0] XS_HI  = GX_W'(XS_LIM);
    localparam logic signed [GX_W-1:0] XS_LO  = -XS_HI;

    // configuration
    logic [31:0] r_act_scale;

    // item and lane results
    t_in_item                   r_item;
    logic signed [ITEM_DOT_W-1:0] r_idot;
    logic signed [ITEM_XS_W-1:0]  r_ixs;

    // group and row state
    logic signed [GD_W-1:0] r_gdot;
    logic signed [GX_W-1:0] r_gxs;
    logic signed [63:0]     r_row_acc;
    logic                   r_row_sat;

    // group close pipeline
    logic signed [63:0]   r_coef;
    logic signed [ZX_W-1:0] r_zx;
    logic signed [T_W-1:0]  r_t;
    logic [63:0]          r_c_mag;
    logic [TP_W-1:0]      r_t_mag;
    logic                 r_neg;
    logic [STEP_W-1:0]    r_step;
    logic [63:0]          r_pp;
    logic [SH_W-1:0]      r_pp_sh;
    logic                 r_pp_vld;
    logic [PROD_W-1:0]    r_prod;
    logic signed [63:0]   r_term;
    logic                 r_term_sat;
    t_out_item            r_out;

    // lane decode
    logic [4:0]               lane_cnt;
    logic [127:0]             acts;
    logic signed [12:0]       lane_prod [LANES];
    logic signed [7:0]        lane_x    [LANES];
    logic signed [ITEM_DOT_W-1:0] item_dot;
    logic signed [ITEM_XS_W-1:0]  item_xs;

    assign lane_cnt = (r_item.valid_count > 5'(LANES)) ? 5'(LANES) : r_item.valid_count;
    assign acts     = {r_item.acts_high, r_item.acts_low};

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic [3:0]        nib;
        logic signed [4:0] q;
        logic signed [7:0] x;
        logic              en;
        assign nib = r_item.weights_packed[4*l +: 4] & NIB_MASK;
        assign q   = $signed({1'b0, nib}) - ZERO_OFFSET;
        assign x   = acts[8*l +: 8];
        assign en  = lane_cnt > 5'(l);
        assign lane_prod[l] = en ? q * x : 13'sd0;
        assign lane_x[l]    = en ? x : 8'sd0;
    end

    // lane reduction
    always_comb begin
        item_dot = '0;
        item_xs  = '0;
        for (int l = 0; l < LANES; l++) begin
            item_dot = item_dot + ITEM_DOT_W'(lane_prod[l]);
            item_xs  = item_xs + ITEM_XS_W'(lane_x[l]);
        end
    end

    // group accumulate with symmetric clamp
    logic signed [GD_W:0] gd_sum;
    logic signed [GX_W:0] gx_sum;
    logic signed [GD_W-1:0] n_gdot;
    logic signed [GX_W-1:0] n_gxs;
    logic                 gd_sat;
    logic                 gx_sat;

    always_comb begin
        gd_sum = (GD_W+1)'(r_gdot) + (GD_W+1)'(r_idot);
        gx_sum = (GX_W+1)'(r_gxs) + (GX_W+1)'(r_ixs);
        gd_sat = 1'b1;
        gx_sat = 1'b1;
        if (gd_sum > (GD_W+1)'(DOT_HI)) begin
            n_gdot = DOT_HI;
        end else if (gd_sum < (GD_W+1)'(DOT_LO)) begin
            n_gdot = DOT_LO;
        end else begin
            n_gdot = gd_sum[GD_W-1:0];
            gd_sat = 1'b0;
        end
        if (gx_sum > (GX_W+1)'(XS_HI)) begin
            n_gxs = XS_HI;
        end else if (gx_sum < (GX_W+1)'(XS_LO)) begin
            n_gxs = XS_LO;
        end else begin
            n_gxs = gx_sum[GX_W-1:0];
            gx_sat = 1'b0;
        end
    end

    // coefficient and zero-point products
    logic signed [64:0] coef_full;
    assign coef_full = r_item.weight_scale * $signed({1'b0, r_act_scale});

    // partial product operand selection
    logic [31:0] c_word;
    logic [31:0] t_word;
    assign c_word = r_step[0] ? r_c_mag[63:32] : r_c_mag[31:0];
    assign t_word = r_t_mag[32 * (r_step >> 1) +: 32];

    // round half away from zero, shift to Q.24, saturate
    logic [PROD_W-1:0] rnd;
    logic [63:0]       rmag;
    logic              rnd_over;
    logic signed [63:0] term;
    logic              term_sat;

    always_comb begin
        rnd      = r_prod + (PROD_W'(1) << RND_BIT);
        rmag     = rnd[TERM_MSB:TERM_LSB];
        rnd_over = |rnd[PROD_W-1:TERM_MSB+1];
        if (!r_neg) begin
            term_sat = rnd_over | rmag[63];
            term     = term_sat ? INT64_MAX : rmag;
        end else begin
            term_sat = rnd_over | (rmag[63] & (|rmag[62:0]));
            term     = term_sat ? INT64_MIN : -rmag;
        end
    end

    // saturating row add
    logic [64:0]        row_sum;
    logic               row_ovf;
    logic signed [63:0] n_row_acc;

    always_comb begin
        row_sum   = {r_row_acc[63], r_row_acc} + {r_term[63], r_term};
        row_ovf   = row_sum[64] ^ row_sum[63];
        n_row_acc = row_ovf ? (row_sum[64] ? INT64_MIN : INT64_MAX) : row_sum[63:0];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_scale <= ACT_SCALE_RST;
            r_gdot      <= '0;
            r_gxs       <= '0;
            r_row_acc   <= '0;
            r_row_sat   <= 1'b0;
            r_step      <= '0;
            r_pp_vld    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_act_scale <= i_cfg_wdata;
            end
            if (i_cmd.gacc) begin
                r_gdot    <= n_gdot;
                r_gxs     <= n_gxs;
                r_row_sat <= r_row_sat | gd_sat | gx_sat;
            end else if (i_cmd.tsub) begin
                r_gdot <= '0;
                r_gxs  <= '0;
            end
            if (i_cmd.radd) begin
                r_row_acc <= n_row_acc;
                r_row_sat <= r_row_sat | r_term_sat | row_ovf;
            end else if (i_cmd.emit) begin
                r_row_acc <= '0;
                r_row_sat <= 1'b0;
            end
            if (i_cmd.mag) begin
                r_step <= '0;
            end else if (i_cmd.mul) begin
                r_step <= r_step + STEP_W'(1);
            end
            r_pp_vld <= i_cmd.mul;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.lane) begin
            r_idot <= item_dot;
            r_ixs  <= item_xs;
        end
        if (i_cmd.coef) begin
            r_coef <= coef_full[63:0];
            r_zx   <= r_item.zero_minus_eight * r_gxs;
        end
        if (i_cmd.tsub) begin
            r_t <= (T_W'(r_gdot) <<< 10) - T_W'(r_zx);
        end
        if (i_cmd.mag) begin
            r_c_mag <= r_coef[63] ? -r_coef : r_coef;
            r_t_mag <= TP_W'(r_t[T_W-1] ? -r_t : r_t);
            r_neg   <= r_coef[63] ^ r_t[T_W-1];
            r_prod  <= '0;
        end else if (r_pp_vld) begin
            r_prod <= r_prod + (PROD_W'(r_pp) << (32 * r_pp_sh));
        end
        if (i_cmd.mul) begin
            r_pp    <= c_word * t_word;
            r_pp_sh <= SH_W'(r_step >> 1) + SH_W'(r_step[0]);
        end
        if (i_cmd.round) begin
            r_term     <= term;
            r_term_sat <= term_sat;
        end
        if (i_cmd.emit) begin
            r_out.row_value <= r_row_acc;
            r_out.saturated <= r_row_sat;
        end
    end

    assign o_stat.group_close = r_item.group_end | r_item.row_end;
    assign o_stat.row_end     = r_item.row_end;
    assign o_stat.last_step   = r_step == STEP_W'(2 * NT - 1);
    assign o_out_item         = r_out;

    // group accumulators stay inside their clamp range
    `IGQDP_ASSERT(a_gdot_range, (r_gdot <= DOT_HI) && (r_gdot >= DOT_LO))
    // closing a group empties it
    `IGQDP_ASSERT_NEXT(a_group_cleared, i_cmd.tsub, (r_gdot == '0) && (r_gxs == '0))

endmodule

/* sv/igqdp_ctrl.sv */
`include "int4_group_quant_dot_product_unit_macros.svh"

module igqdp_ctrl import igqdp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    output logic     o_valid,
    input  logic     i_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LANE  = 4'd1;
    localparam logic [3:0] S_GACC  = 4'd2;
    localparam logic [3:0] S_COEF  = 4'd3;
    localparam logic [3:0] S_TSUB  = 4'd4;
    localparam logic [3:0] S_MAG   = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_DRAIN = 4'd7;
    localparam logic [3:0] S_ROUND = 4'd8;
    localparam logic [3:0] S_RADD  = 4'd9;
    localparam logic [3:0] S_EMIT  = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       in_take;
    logic       out_take;
    logic       out_free;

    assign in_take  = i_valid & ~o_stall;
    assign out_take = r_out_valid & ~i_stall;
    assign out_free = ~r_out_valid | ~i_stall;

    // sequencer
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LANE;
                end
            end
            S_LANE: begin
                o_cmd.lane = 1'b1;
                n_state    = S_GACC;
            end
            S_GACC: begin
                o_cmd.gacc = 1'b1;
                n_state    = i_stat.group_close ? S_COEF : S_IDLE;
            end
            S_COEF: begin
                o_cmd.coef = 1'b1;
                n_state    = S_TSUB;
            end
            S_TSUB: begin
                o_cmd.tsub = 1'b1;
                n_state    = S_MAG;
            end
            S_MAG: begin
                o_cmd.mag = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                if (i_stat.last_step) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                n_state     = S_RADD;
            end
            S_RADD: begin
                o_cmd.radd = 1'b1;
                n_state    = i_stat.row_end ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (out_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = r_state != S_IDLE;
    assign o_valid = r_out_valid;

    // a pending result is never overwritten
    `IGQDP_ASSERT(a_no_overwrite, (r_out_valid && i_stall) |-> !o_cmd.emit)
    // a result appears only after the output register was loaded
    `IGQDP_ASSERT(a_valid_from_emit, $rose(o_valid) |-> $past(o_cmd.emit))
    // only a row end produces a result
    `IGQDP_ASSERT(a_emit_row_end, o_cmd.emit |-> i_stat.row_end)

endmodule
